// File: hdl/sierra_lite_error_diffusion_macros.svh
// Assertion macros shared by the Sierra Lite error diffusion RTL.
`ifndef SIERRA_LITE_ERROR_DIFFUSION_MACROS_SVH
`define SIERRA_LITE_ERROR_DIFFUSION_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SLED_ASSERT_IMPL(name, clk_i, rstn_i, ante, cons, msg) \
	name: assert property (@(posedge clk_i) disable iff (!rstn_i) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define SLED_ASSERT_NEXT(name, clk_i, rstn_i, ante, cons, msg) \
	name: assert property (@(posedge clk_i) disable iff (!rstn_i) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: hdl/sled_pkg.sv
// Shared constants, types and arithmetic helpers of the Sierra Lite error diffusion block.
package sled_pkg;

	localparam int MAX_WIDTH  = 2048;
	localparam int COL_W      = $clog2(MAX_WIDTH);
	localparam int WID_W      = COL_W + 1;
	localparam int PIX_W      = 8;
	localparam int FW_W       = 12;
	localparam int CFG_DATA_W = 12;
	localparam int CFG_IDX_W  = 1;
	localparam int ERR_W      = PIX_W + 1;
	localparam int ACC_W      = PIX_W + 4;

	localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD   = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH = CFG_IDX_W'(1);

	localparam logic [PIX_W-1:0] THRESHOLD_RST   = PIX_W'(128);
	localparam logic [FW_W-1:0]  FRAME_WIDTH_RST = FW_W'(640);
	localparam logic [PIX_W-1:0] PIX_MAX         = PIX_W'(255);

	localparam logic signed [ACC_W-1:0] ACC_MAX = ACC_W'(1020);

	typedef enum logic {
		REQ_PIXEL = 1'b0,
		REQ_FLUSH = 1'b1
	} req_type_t;

	typedef struct packed {
		logic [PIX_W-1:0] threshold;
		logic [WID_W-1:0] width;
	} cfg_t;

	typedef struct packed {
		logic             flush;
		logic             hp;
		logic             bank;
		logic             last;
		logic [COL_W-1:0] col;
		logic [PIX_W-1:0] pix;
	} item_t;

	typedef struct packed {
		logic             en;
		logic             bank;
		logic [COL_W-1:0] addr;
		logic [PIX_W-1:0] data;
	} wr_t;

	// Limits the programmed row length to the range the row stores support.
	function automatic logic [WID_W-1:0] clamp_width(input logic [FW_W-1:0] fw);
		logic [31:0] t;
		t = 32'(fw);
		if (t == 32'd0) t = 32'd1;
		if (t > 32'(MAX_WIDTH)) t = 32'(MAX_WIDTH);
		return t[WID_W-1:0];
	endfunction

	// Computes clamp(4*v + k*e, 0, 1020) >> 2 with k equal to 2 or 1.
	function automatic logic [PIX_W-1:0] spread(input logic [PIX_W-1:0] v, input logic dbl,
			input logic signed [ERR_W-1:0] e);
		logic signed [ACC_W-1:0] k_e;
		logic signed [ACC_W-1:0] t;
		logic [PIX_W-1:0] r;
		k_e = dbl ? (ACC_W'(e) <<< 1) : ACC_W'(e);
		t = $signed({2'b00, v, 2'b00}) + k_e;
		if (t[ACC_W-1]) begin
			r = '0;
		end else if (t > ACC_MAX) begin
			r = '1;
		end else begin
			r = t[PIX_W+1:2];
		end
		return r;
	endfunction

endpackage

// File: hdl/sled_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
module sled_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2048
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// File: hdl/sled_cfg.sv
// Configuration registers with the clamped active row length.
module sled_cfg (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [sled_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [sled_pkg::CFG_DATA_W-1:0]    cfg_data,
	output sled_pkg::cfg_t                     cfg
);

	import sled_pkg::*;

	logic [PIX_W-1:0] threshold_q;
	logic [FW_W-1:0]  frame_width_q;
	logic [WID_W-1:0] width_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			threshold_q   <= THRESHOLD_RST;
			frame_width_q <= FRAME_WIDTH_RST;
			width_q       <= clamp_width(FRAME_WIDTH_RST);
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_THRESHOLD: begin
						threshold_q <= cfg_data[PIX_W-1:0];
					end
					REG_FRAME_WIDTH: begin
						frame_width_q <= cfg_data[FW_W-1:0];
					end
					default: begin
					end
				endcase
			end
			width_q <= clamp_width(frame_width_q);
		end
	end

	assign cfg.threshold = threshold_q;
	assign cfg.width     = width_q;

endmodule

// File: hdl/sled_ctrl.sv
// Input sequencer: column, row bank and stored-row tracking, row store read issue.
`include "sierra_lite_error_diffusion_macros.svh"

module sled_ctrl (
	input  logic                          clk,
	input  logic                          arst_n,
	input  sled_pkg::cfg_t                cfg,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic                          req_type,
	input  logic [sled_pkg::PIX_W-1:0]    pixel_in,
	input  logic                          stage_free,
	output logic                          item_valid,
	output sled_pkg::item_t               item,
	output logic                          rd_en,
	output logic [sled_pkg::COL_W-1:0]    rd_addr
);

	import sled_pkg::*;

	logic [COL_W-1:0] col_q;
	logic             hp_q;
	logic             bank_q;
	logic [COL_W-1:0] x;
	logic             flush;
	logic             last;
	logic             ignore;
	logic             accept;

	always_comb begin
		x          = ({1'b0, col_q} >= cfg.width) ? '0 : col_q;
		flush      = (req_type == REQ_FLUSH);
		last       = ({1'b0, x} == (cfg.width - WID_W'(1)));
		ignore     = flush && !hp_q;
		accept     = in_valid && stage_free;
		in_ready   = stage_free;
		item_valid = accept && !ignore;
		item.flush = flush;
		item.hp    = hp_q;
		item.bank  = bank_q;
		item.last  = last;
		item.col   = x;
		item.pix   = pixel_in;
		rd_en      = item_valid;
		rd_addr    = x;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q  <= '0;
			hp_q   <= 1'b0;
			bank_q <= 1'b0;
		end else if (accept) begin
			if (ignore) begin
				col_q <= x;
			end else if (last) begin
				col_q <= '0;
				if (flush) begin
					hp_q <= 1'b0;
				end else begin
					hp_q   <= 1'b1;
					bank_q <= ~bank_q;
				end
			end else begin
				col_q <= x + COL_W'(1);
			end
		end
	end

	`SLED_ASSERT_IMPL(a_flush_has_row, clk, arst_n, item_valid && item.flush, item.hp, "flush word entered the datapath without a stored row")
	`SLED_ASSERT_NEXT(a_row_swap, clk, arst_n, item_valid && item.last && !item.flush, hp_q && (bank_q != $past(bank_q)), "pixel row end did not swap the row banks")

endmodule

// File: hdl/sled_core.sv
// Compute stage: forwarding, threshold, error spread, row store write-back and result register.
`include "sierra_lite_error_diffusion_macros.svh"

module sled_core (
	input  logic                          clk,
	input  logic                          arst_n,
	input  sled_pkg::cfg_t                cfg,
	input  logic                          item_valid,
	input  sled_pkg::item_t               item,
	output logic                          stage_free,
	input  logic [sled_pkg::PIX_W-1:0]    rd0,
	input  logic [sled_pkg::PIX_W-1:0]    rd1,
	output sled_pkg::wr_t                 wr,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [sled_pkg::PIX_W-1:0]    pixel_out,
	output logic                          frame_end
);

	import sled_pkg::*;

	logic                     v_s1;
	item_t                    item_s1;
	logic                     out_v_q;
	logic [PIX_W-1:0]         pixel_out_q;
	logic                     frame_end_q;
	logic signed [ERR_W-1:0]  err_q;
	logic                     pend_v_q;
	logic                     pend_bank_q;
	logic [COL_W-1:0]         pend_addr_q;
	logic [PIX_W-1:0]         pend_val_q;
	logic                     lw_v_q;
	logic                     lw_bank_q;
	logic [COL_W-1:0]         lw_addr_q;
	logic [PIX_W-1:0]         lw_data_q;

	logic                     commit;
	logic                     first_col;
	logic [PIX_W-1:0]         rd_sel;
	logic [PIX_W-1:0]         raw_c;
	logic [PIX_W-1:0]         old;
	logic [PIX_W-1:0]         q;
	logic signed [ERR_W-1:0]  err_new;
	logic [PIX_W-1:0]         pend_new;

	always_comb begin
		commit     = v_s1 && (!item_s1.hp || !out_v_q || out_ready);
		stage_free = !v_s1 || commit;
		first_col  = (item_s1.col == '0);
		rd_sel     = item_s1.bank ? rd1 : rd0;
		if (pend_v_q && (pend_bank_q == item_s1.bank) && (pend_addr_q == item_s1.col)) begin
			raw_c = pend_val_q;
		end else if (lw_v_q && (lw_bank_q == item_s1.bank) && (lw_addr_q == item_s1.col)) begin
			raw_c = lw_data_q;
		end else begin
			raw_c = rd_sel;
		end
		old      = first_col ? raw_c : spread(raw_c, 1'b1, err_q);
		q        = (old < cfg.threshold) ? '0 : PIX_MAX;
		err_new  = item_s1.hp ? ($signed({1'b0, old}) - $signed({1'b0, q})) : '0;
		pend_new = item_s1.flush ? raw_c : spread(item_s1.pix, 1'b0, err_new);
		wr.en    = commit && pend_v_q;
		wr.bank  = pend_bank_q;
		wr.addr  = pend_addr_q;
		wr.data  = (!first_col && !item_s1.flush) ? spread(pend_val_q, 1'b0, err_new)
			: pend_val_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1     <= 1'b0;
			out_v_q  <= 1'b0;
			pend_v_q <= 1'b0;
			lw_v_q   <= 1'b0;
		end else begin
			if (stage_free) begin
				v_s1 <= item_valid;
			end
			if (commit && item_s1.hp) begin
				out_v_q <= 1'b1;
			end else if (out_ready) begin
				out_v_q <= 1'b0;
			end
			if (commit) begin
				pend_v_q <= 1'b1;
			end
			if (wr.en) begin
				lw_v_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (stage_free && item_valid) begin
			item_s1 <= item;
		end
		if (commit) begin
			err_q       <= err_new;
			pend_bank_q <= ~item_s1.bank;
			pend_addr_q <= item_s1.col;
			pend_val_q  <= pend_new;
		end
		if (commit && item_s1.hp) begin
			pixel_out_q <= q;
			frame_end_q <= item_s1.flush && item_s1.last;
		end
		if (wr.en) begin
			lw_bank_q <= wr.bank;
			lw_addr_q <= wr.addr;
			lw_data_q <= wr.data;
		end
	end

	assign out_valid = out_v_q;
	assign pixel_out = pixel_out_q;
	assign frame_end = frame_end_q;

	`SLED_ASSERT_IMPL(a_left_tap_addr, clk, arst_n, wr.en && !first_col, pend_addr_q == (item_s1.col - COL_W'(1)), "left neighbor write-back is not at the previous column")
	`SLED_ASSERT_IMPL(a_out_hold, clk, arst_n, out_v_q && !out_ready, !(commit && item_s1.hp), "waiting result word was overwritten")

endmodule

// File: hdl/sierra_lite_error_diffusion.sv
// Top level of the Sierra Lite error diffusion block for one 8-bit image channel.
//
//   channel  | handshake            | payload
//   ---------+----------------------+------------------------------
//   in       | in_valid / in_ready  | req_type, pixel_in
//   out      | out_valid / out_ready| pixel_out, frame_end
//   cfg      | cfg_we               | cfg_index, cfg_data
//
// One word is taken per clock while in_ready is high; the error loop through the single compute stage and
// one write per word to one row bank set that figure. A result passes the compute stage and the output register.
// Reset clears control only; the two row banks are not cleared and need no clearing pass.
// With out_ready low, one result waits in the output register and one in the compute stage;
// in_ready drops only when both are full.
module sierra_lite_error_diffusion (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [sled_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [sled_pkg::CFG_DATA_W-1:0]    cfg_data,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic                               req_type,
	input  logic [sled_pkg::PIX_W-1:0]         pixel_in,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic [sled_pkg::PIX_W-1:0]         pixel_out,
	output logic                               frame_end
);

	import sled_pkg::*;

	cfg_t             cfg;
	item_t            item;
	wr_t              wr;
	logic             item_valid;
	logic             stage_free;
	logic             rd_en;
	logic [COL_W-1:0] rd_addr;
	logic [PIX_W-1:0] rd0;
	logic [PIX_W-1:0] rd1;

	sled_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	sled_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.req_type   (req_type),
		.pixel_in   (pixel_in),
		.stage_free (stage_free),
		.item_valid (item_valid),
		.item       (item),
		.rd_en      (rd_en),
		.rd_addr    (rd_addr)
	);

	sled_ram #(
		.WIDTH (PIX_W),
		.DEPTH (MAX_WIDTH)
	) u_bank0 (
		.clk   (clk),
		.we    (wr.en && (wr.bank == 1'b0)),
		.waddr (wr.addr),
		.wdata (wr.data),
		.re    (rd_en),
		.raddr (rd_addr),
		.rdata (rd0)
	);

	sled_ram #(
		.WIDTH (PIX_W),
		.DEPTH (MAX_WIDTH)
	) u_bank1 (
		.clk   (clk),
		.we    (wr.en && (wr.bank == 1'b1)),
		.waddr (wr.addr),
		.wdata (wr.data),
		.re    (rd_en),
		.raddr (rd_addr),
		.rdata (rd1)
	);

	sled_core u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg),
		.item_valid (item_valid),
		.item       (item),
		.stage_free (stage_free),
		.rd0        (rd0),
		.rd1        (rd1),
		.wr         (wr),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.pixel_out  (pixel_out),
		.frame_end  (frame_end)
	);

endmodule
